// ===== hw/rtl/itrs_pkg.sv =====
// ----------------------------------------------------------------------------
// itrs_pkg: shared definitions for the integer to radix string block
// Sequencer states, register indexes, character codes and the divider step.
// ----------------------------------------------------------------------------
package itrs_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } itrs_state_t;

  // Widths and limits fixed by the register layout
  localparam int DEF_VALUE_BITS = 32;
  localparam int MAX_RADIX      = 16;
  localparam int ALPHA_SLOTS    = 16;
  localparam int SYM_W          = 8;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int SLOT_W         = 4;
  localparam int CHUNK_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  // Character codes
  localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
  localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_NONE  = 8'd0;

  // One divider step result: partial remainder and quotient bits
  typedef struct packed {
    logic [RADIX_W-1:0] rem;
    logic [CHUNK_W-1:0] quo;
  } div_step_t;

  // Whitespace and sign characters may not serve as digits
  function automatic logic is_forbidden(input logic [SYM_W-1:0] c);
    return c inside {[CH_TAB:CH_CR], CH_SPACE, CH_PLUS, CH_MINUS};
  endfunction

  // Restoring division of {rem, nib} by r, one dividend bit per step
  function automatic div_step_t div_step(input logic [RADIX_W-1:0] rem,
                                         input logic [CHUNK_W-1:0] nib,
                                         input logic [RADIX_W-1:0] r);
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] cur;
    div_step_t          res;
    cur = rem;
    res.quo = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      t = {cur, nib[b]};
      if (t >= {1'b0, r}) begin
        cur = RADIX_W'(t - {1'b0, r});
        res.quo[b] = 1'b1;
      end else begin
        cur = t[RADIX_W-1:0];
      end
    end
    res.rem = cur;
    return res;
  endfunction

endpackage

// ===== hw/rtl/integer_to_radix_string_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_string_top: signed integer to text in a configured radix
// Checks the alphabet, extracts digits with a shared chunk divider, then
// streams sign and digit characters most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Write radix (index 0) and the two alphabet words (indexes 1 and 2) on the
//   cfg port while the block is idle. Each input beat carries one signed
//   value; the output stream carries one character per beat, '-' first for
//   negatives, tlast on the final digit. An invalid radix or alphabet gives a
//   single beat with tdata zero, tuser set and tlast set.
//   Sequence: the alphabet check visits one symbol at a time (up to 16).
//   Digit extraction runs one 4-bit chunk of the magnitude per cycle through
//   the shared divider, and each digit is one full pass over the chunks of
//   the magnitude. Each digit character then goes through a digit memory
//   read, an output load and its beat; the '-' beat is loaded at the end of
//   the division. After the last beat the block returns to idle, and only
//   then takes the next input beat.
//   The input is ready only when the block is idle; while the receiver
//   stalls, the output beat holds and the block waits.
//   Reset clears the sequencer and the configuration registers to zero.
// ----------------------------------------------------------------------------
module integer_to_radix_string_top
  import itrs_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [SYM_W-1:0]                    m_axis_tdata,  // out_char
  output logic                                m_axis_tlast,
  output logic [0:0]                          m_axis_tuser,  // bad_base
  // configuration write port
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_addr,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata
);

  localparam int MAG_W  = ((VALUE_BITS + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
  localparam int NCHUNK = MAG_W / CHUNK_W;
  localparam int CNT_W  = $clog2(NCHUNK);
  localparam int PTR_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  // Configuration registers
  logic [RADIX_W-1:0]        radix;
  logic [CFG_DATA_W-1:0]     alphabet_low;
  logic [CFG_DATA_W-1:0]     alphabet_high;
  logic [2*CFG_DATA_W-1:0]   alpha;

  // Sequencer and datapath registers
  itrs_state_t               state, state_next;
  logic                      neg;
  logic [MAG_W-1:0]          w;
  logic [RADIX_W-1:0]        rem;
  logic [CNT_W-1:0]          chunk_cnt;
  logic [PTR_W-1:0]          nd;
  logic [SLOT_W-1:0]         chk_idx;
  logic [SYM_W-1:0]          out_char;
  logic                      out_last;
  logic                      out_bad;

  // Digit memory
  logic [DIGIT_W-1:0]        digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]        rd_data;
  logic [PTR_W-1:0]          rd_ptr;

  // Combinational helpers
  logic [VALUE_BITS-1:0]     raw;
  logic [VALUE_BITS-1:0]     mag;
  logic [SYM_W-1:0]          cur_sym;
  logic                      chk_bad;
  logic                      chk_done;
  div_step_t                 step;
  logic [MAG_W-1:0]          w_next;
  logic                      digit_end;
  logic                      div_done;
  logic                      in_beat;
  logic                      out_beat;

  assign alpha = {alphabet_high, alphabet_low};

  // Take configuration writes; unused index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIX:      radix         <= cfg_wdata[RADIX_W-1:0];
        REG_ALPHA_LOW:  alphabet_low  <= cfg_wdata;
        REG_ALPHA_HIGH: alphabet_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Form magnitude of the incoming value
  assign raw = s_axis_tdata[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Check one alphabet symbol against the rules and all earlier symbols
  always_comb begin
    cur_sym = alpha[chk_idx*SYM_W +: SYM_W];
    chk_bad = (radix < RADIX_W'(2)) || (int'(radix) > MAX_RADIX) ||
              (int'(radix) > ALPHA_SLOTS) || is_forbidden(cur_sym);
    for (int j = 0; j < ALPHA_SLOTS; j++) begin
      if ((SLOT_W'(j) < chk_idx) && (alpha[j*SYM_W +: SYM_W] == cur_sym)) begin
        chk_bad = 1'b1;
      end
    end
    chk_done = (({1'b0, chk_idx} + 1'b1) == radix);
  end

  // Divide the working value by radix, one chunk per cycle
  always_comb begin
    step      = div_step(rem, w[MAG_W-1 -: CHUNK_W], radix);
    w_next    = {w[MAG_W-CHUNK_W-1:0], step.quo};
    digit_end = (chunk_cnt == CNT_W'(NCHUNK - 1));
    div_done  = digit_end && (w_next == '0);
  end

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign rd_ptr   = nd - 1'b1;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_SEND);
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk_bad) begin
          state_next = ST_SEND;
        end else if (chk_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = neg ? ST_SEND : ST_FETCH;
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SEND;
      ST_SEND: begin
        if (out_beat) state_next = out_last ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance counters and the working value
  always_ff @(posedge clk) begin
    if (rst) begin
      nd        <= '0;
      chunk_cnt <= '0;
      chk_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            nd        <= '0;
            chunk_cnt <= '0;
            chk_idx   <= '0;
          end
        end
        ST_CHECK: chk_idx <= chk_idx + 1'b1;
        ST_DIV: begin
          if (digit_end) begin
            chunk_cnt <= '0;
            nd        <= nd + 1'b1;
          end else begin
            chunk_cnt <= chunk_cnt + 1'b1;
          end
        end
        ST_LOAD: nd <= nd - 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers: working value, remainder, output beat
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          neg <= raw[VALUE_BITS-1];
          w   <= MAG_W'(mag);
          rem <= '0;
        end
      end
      ST_CHECK: begin
        if (chk_bad) begin
          out_char <= CH_NONE;
          out_last <= 1'b1;
          out_bad  <= 1'b1;
        end
      end
      ST_DIV: begin
        w   <= w_next;
        rem <= digit_end ? '0 : step.rem;
        if (div_done) begin
          out_char <= CH_MINUS;
          out_last <= 1'b0;
          out_bad  <= 1'b0;
        end
      end
      ST_LOAD: begin
        out_char <= alpha[rd_data*SYM_W +: SYM_W];
        out_last <= (nd == PTR_W'(1));
        out_bad  <= 1'b0;
      end
      default: ;
    endcase
  end

  // Store each finished digit; read the next one to emit
  always_ff @(posedge clk) begin
    if (state == ST_DIV && digit_end) begin
      digit_mem[nd[ADDR_W-1:0]] <= step.rem[DIGIT_W-1:0];
    end
    rd_data <= digit_mem[rd_ptr[ADDR_W-1:0]];
  end

  assign m_axis_tdata    = out_char;
  assign m_axis_tlast    = out_last;
  assign m_axis_tuser[0] = out_bad;

  // Input and output never handshake in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while an output beat is pending");

  // Error beat is a single zero character closing the result
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == CH_NONE))
    else $error("error beat malformed");

  // Partial remainder stays below the radix
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < radix))
    else $error("divider remainder out of range");

  // A digit load always has a stored digit behind it
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (nd != '0))
    else $error("digit load with empty digit memory");

endmodule
